[design/bsd_pkg.sv]
// ----------------------------------------------------------------------------
// bsd_pkg: shared constants for the box signed distance unit
// Field widths fixed by the interface and the edge length reset value.
// ----------------------------------------------------------------------------
package bsd_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int EDGE_W          = 16;
   localparam int OUT_W           = 18;

   localparam logic [EDGE_W-1:0] EDGE_RESET = 16'd256;

endpackage

[design/bsd_front.sv]
// ----------------------------------------------------------------------------
// bsd_front: per-axis distances, squares and their sum
// Three stages: |c| - edge/2, clamped squares, sum plus inside term.
// ----------------------------------------------------------------------------
module bsd_front import bsd_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int D_W         = COORD_WIDTH + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [EDGE_W-1:0]             edge_length,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [COORD_WIDTH-1:0]        point_x,
   input  logic [COORD_WIDTH-1:0]        point_y,
   input  logic [COORD_WIDTH-1:0]        point_z,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [2*COORD_WIDTH-1:0]      sum_sq,
   output logic signed [D_W-1:0]         inner
);

   localparam int W   = COORD_WIDTH;
   localparam int SQW = 2 * COORD_WIDTH;

   logic [W-1:0]          coord [3];
   logic [W-1:0]          mag   [3];
   logic signed [D_W-1:0] d_in  [3];
   logic [W-1:0]          p_in  [3];
   logic signed [D_W-1:0] d_ff  [3];
   logic [W-1:0]          p_ff  [3];
   logic [SQW-1:0]        sq_ff [3];
   logic signed [D_W-1:0] inner1_in;
   logic signed [D_W-1:0] inner1_ff;
   logic signed [D_W-1:0] dmax;
   logic [SQW-1:0]        sum_ff;
   logic signed [D_W-1:0] inner2_ff;
   logic [EDGE_W-2:0]     half;
   logic                  v0_ff, v1_ff, v2_ff;
   logic                  rdy0, rdy1, rdy2;

   assign coord[0] = point_x;
   assign coord[1] = point_y;
   assign coord[2] = point_z;
   assign half     = edge_length[EDGE_W-1:1];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         // most negative value wraps to 2^(W-1), correct as unsigned
         mag[i]  = coord[i][W-1] ? (~coord[i] + 1'b1) : coord[i];
         d_in[i] = $signed(D_W'({1'b0, mag[i]})) - $signed(D_W'({1'b0, half}));
         p_in[i] = (d_in[i] > 0) ? d_in[i][W-1:0] : '0;
      end
   end

   always_comb begin
      dmax = d_ff[0];
      if (d_ff[1] > dmax) dmax = d_ff[1];
      if (d_ff[2] > dmax) dmax = d_ff[2];
      inner1_in = (dmax < 0) ? dmax : '0;
   end

   assign rdy2     = !v2_ff || out_ready;
   assign rdy1     = !v1_ff || rdy2;
   assign rdy0     = !v0_ff || rdy1;
   assign in_ready = rdy0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (rdy0) v0_ff <= in_valid;
         if (rdy1) v1_ff <= v0_ff;
         if (rdy2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy0 && in_valid) begin
         for (int i = 0; i < 3; i++) begin
            d_ff[i] <= d_in[i];
            p_ff[i] <= p_in[i];
         end
      end
      if (rdy1 && v0_ff) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= p_ff[i] * p_ff[i];
         end
         inner1_ff <= inner1_in;
      end
      if (rdy2 && v1_ff) begin
         // three squares each at most 2^(2W-2): no overflow
         sum_ff    <= sq_ff[0] + sq_ff[1] + sq_ff[2];
         inner2_ff <= inner1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign sum_sq    = sum_ff;
   assign inner     = inner2_ff;

endmodule

[design/bsd_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// bsd_sqrt_cell: one step of the digit-by-digit integer square root
// Takes two radicand bits, yields one root bit, hands state to the next cell.
// ----------------------------------------------------------------------------
module bsd_sqrt_cell #(
   parameter int ROOT_W = 16,
   parameter int D_W    = 17
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [ROOT_W+1:0]       rem_i,
   input  logic [ROOT_W-1:0]       root_i,
   input  logic [2*ROOT_W-1:0]     rad_i,
   input  logic signed [D_W-1:0]   inner_i,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [ROOT_W+1:0]       rem_o,
   output logic [ROOT_W-1:0]       root_o,
   output logic [2*ROOT_W-1:0]     rad_o,
   output logic signed [D_W-1:0]   inner_o
);

   localparam int REM_W = ROOT_W + 2;
   localparam int RAD_W = 2 * ROOT_W;

   logic [REM_W-1:0]      rem_sh;
   logic [REM_W-1:0]      trial;
   logic                  take;
   logic [REM_W-1:0]      rem_in;
   logic [ROOT_W-1:0]     root_in;
   logic [RAD_W-1:0]      rad_in;
   logic [REM_W-1:0]      rem_ff;
   logic [ROOT_W-1:0]     root_ff;
   logic [RAD_W-1:0]      rad_ff;
   logic signed [D_W-1:0] inner_ff;
   logic                  valid_ff;

   always_comb begin
      rem_sh  = {rem_i[REM_W-3:0], rad_i[RAD_W-1 -: 2]};
      trial   = {root_i, 2'b01};
      take    = (rem_sh >= trial);
      rem_in  = take ? (rem_sh - trial) : rem_sh;
      root_in = {root_i[ROOT_W-2:0], take};
      rad_in  = {rad_i[RAD_W-3:0], 2'b00};
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rem_ff   <= rem_in;
         root_ff  <= root_in;
         rad_ff   <= rad_in;
         inner_ff <= inner_i;
      end
   end

   assign out_valid = valid_ff;
   assign rem_o     = rem_ff;
   assign root_o    = root_ff;
   assign rad_o     = rad_ff;
   assign inner_o   = inner_ff;

endmodule

[design/box_signed_distance_unit.sv]
// ----------------------------------------------------------------------------
// box_signed_distance_unit: signed distance from a point to a centered cube
// Pipeline: three front stages, one square-root cell per root bit, one output
// register. Throughput: one point per cycle unless rsp_tready back-pressure
// stalls it; the root cells form a stalling pipeline.
// Reset: synchronous; clears all valid flags, edge length returns to 1.0.
// ----------------------------------------------------------------------------
module box_signed_distance_unit import bsd_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [EDGE_W-1:0]                      csr_data,   // edge_length
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // point_x, point_y, point_z, zero pad
   input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]     req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [((OUT_W+7)/8)*8-1:0]             rsp_tdata   // distance, zero pad
);

   localparam int W      = COORD_WIDTH;
   localparam int HALF_W = EDGE_W - 1;
   localparam int D_W    = ((W > HALF_W) ? W : HALF_W) + 1;
   localparam int REM_W  = W + 2;
   localparam int RAD_W  = 2 * W;
   localparam int ACC_W  = D_W + 2;
   localparam int RSP_W  = ((OUT_W + 7) / 8) * 8;

   logic [EDGE_W-1:0]     edge_ff;
   logic                  f_valid;
   logic [RAD_W-1:0]      f_sum;
   logic signed [D_W-1:0] f_inner;

   logic                  c_valid [W+1];
   logic                  c_ready [W+1];
   logic [REM_W-1:0]      c_rem   [W+1];
   logic [W-1:0]          c_root  [W+1];
   logic [RAD_W-1:0]      c_rad   [W+1];
   logic signed [D_W-1:0] c_inner [W+1];

   logic                  rsp_valid_ff;
   logic [OUT_W-1:0]      dist_ff;
   logic signed [ACC_W-1:0] dist_acc;
   logic                  out_load;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_ff <= EDGE_RESET;
      end else if (csr_valid) begin
         edge_ff <= csr_data;
      end
   end

   bsd_front #(
      .COORD_WIDTH (W),
      .D_W         (D_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .edge_length (edge_ff),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .point_x     (req_tdata[W-1:0]),
      .point_y     (req_tdata[2*W-1:W]),
      .point_z     (req_tdata[3*W-1:2*W]),
      .out_valid   (f_valid),
      .out_ready   (c_ready[0]),
      .sum_sq      (f_sum),
      .inner       (f_inner)
   );

   assign c_valid[0] = f_valid;
   assign c_rem[0]   = '0;
   assign c_root[0]  = '0;
   assign c_rad[0]   = f_sum;
   assign c_inner[0] = f_inner;

   for (genvar k = 0; k < W; k++) begin : g_cell
      bsd_sqrt_cell #(
         .ROOT_W (W),
         .D_W    (D_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (c_valid[k]),
         .in_ready  (c_ready[k]),
         .rem_i     (c_rem[k]),
         .root_i    (c_root[k]),
         .rad_i     (c_rad[k]),
         .inner_i   (c_inner[k]),
         .out_valid (c_valid[k+1]),
         .out_ready (c_ready[k+1]),
         .rem_o     (c_rem[k+1]),
         .root_o    (c_root[k+1]),
         .rad_o     (c_rad[k+1]),
         .inner_o   (c_inner[k+1])
      );
   end

   assign out_load   = !rsp_valid_ff || rsp_tready;
   assign c_ready[W] = out_load;

   // inside term is never positive, root never negative
   assign dist_acc = ACC_W'(c_inner[W]) + $signed(ACC_W'({1'b0, c_root[W]}));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= c_valid[W];
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && c_valid[W]) begin
         dist_ff <= dist_acc[OUT_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(dist_ff);

endmodule

[tb/tb_box_signed_distance_unit.sv]
// ----------------------------------------------------------------------------
// tb_box_signed_distance_unit: stream test of the box signed distance unit
// Query points go in through a queue-fed driver. Each accepted request is
// scored against a built-in distance calculation, using the edge length that
// is in force at the time. Both stream sides idle at random. The edge length
// is rewritten between phases, once the pipeline has drained.
// ----------------------------------------------------------------------------
module tb_box_signed_distance_unit;
   import bsd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW         = COORD_WIDTH_DEF;
   localparam int IDLE_LIMIT = 2000;

   typedef logic signed [CW-1:0] coord_t;
   typedef struct {
      coord_t x;
      coord_t y;
      coord_t z;
   } point_t;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [EDGE_W-1:0]               csr_data = '0;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [((3*CW+7)/8)*8-1:0]       req_tdata = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [((OUT_W+7)/8)*8-1:0]      rsp_tdata;

   point_t                  pending[$];
   logic signed [OUT_W-1:0] distance_due[$];

   logic [EDGE_W-1:0] edge_cfg = EDGE_RESET;
   bit                req_taken = 1'b0;
   bit                rsp_taken = 1'b0;
   bit                csr_taken = 1'b0;
   int                send_gap = 0;
   int                rx_wait = 0;
   bit                tx_calm = 1'b0;
   bit                rx_calm = 1'b0;
   int                fault_count = 0;
   int                idle_cycles = 0;

   box_signed_distance_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Distance from point to the cube of the given edge: negative part from the
   // largest axis excess, positive part from the root of summed outside squares.
   function automatic logic signed [OUT_W-1:0] box_distance(coord_t px, coord_t py,
                                                            coord_t pz,
                                                            logic [EDGE_W-1:0] edge_len);
      longint half;
      longint excess[3];
      longint mag;
      longint worst;
      longint sq_sum;
      longint root;
      longint trial;
      coord_t axis[3];
      begin
         axis[0] = px;
         axis[1] = py;
         axis[2] = pz;
         half    = longint'(edge_len >> 1);
         sq_sum  = 0;
         for (int i = 0; i < 3; i++) begin
            mag = longint'(axis[i]);
            if (mag < 0)
               mag = -mag;
            excess[i] = mag - half;
            if (excess[i] > 0)
               sq_sum += excess[i] * excess[i];
         end
         worst = excess[0];
         if (excess[1] > worst)
            worst = excess[1];
         if (excess[2] > worst)
            worst = excess[2];
         if (worst > 0)
            worst = 0;
         // root < 2^17 for any 16-bit inputs
         root = 0;
         for (int b = 17; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= sq_sum)
               root = trial;
         end
         return OUT_W'(worst + root);
      end
   endfunction

   function automatic int draw_wait(inout bit calm);
      if ($urandom_range(0, 49) == 0)
         calm = !calm;
      return calm ? 0 : $urandom_range(0, 10);
   endfunction

   // random coordinate, biased toward the faces of the current cube
   function automatic coord_t pick_coord(int half);
      logic [CW-1:0] raw;
      longint        v;
      begin
         raw = CW'($urandom);
         case ($urandom_range(0, 3))
            0: v = longint'($signed(raw));
            1: v = longint'($urandom_range(0, half));
            2: v = longint'(half) + longint'($urandom_range(0, 16)) - 8;
            default: v = longint'(half) + longint'($urandom_range(0, 3000));
         endcase
         if ($urandom_range(0, 1))
            v = -v;
         if (v > 32767)
            v = 32767;
         if (v < -32768)
            v = -32768;
         return coord_t'(v);
      end
   endfunction

   task automatic note_fault(string msg);
      fault_count++;
      if (fault_count <= 10)
         $display("%t: %s", $realtime, msg);
   endtask

   // request driver
   always @(negedge clock) begin
      point_t p;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // hold until accepted
      end else if (send_gap > 0) begin
         req_tvalid <= 1'b0;
         send_gap   <= send_gap - 1;
      end else if (pending.size() != 0) begin
         p = pending.pop_front();
         req_tdata  <= {p.z, p.y, p.x};
         req_tvalid <= 1'b1;
         send_gap   <= draw_wait(tx_calm);
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // result sink with random back-pressure
   always @(negedge clock) begin
      int n;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rx_wait > 0) begin
         rx_wait    <= rx_wait - 1;
         rsp_tready <= (rx_wait == 1);
      end else if (rsp_taken || !rsp_tready) begin
         n = draw_wait(rx_calm);
         rx_wait    <= n;
         rsp_tready <= (n == 0);
      end
   end

   // monitor, scoreboard and watchdog
   always @(posedge clock) begin
      logic signed [OUT_W-1:0] want;
      req_taken <= req_tvalid && req_tready;
      rsp_taken <= rsp_tvalid && rsp_tready;
      csr_taken <= csr_valid && csr_ready;
      if (reset) begin
         edge_cfg    <= EDGE_RESET;
         idle_cycles <= 0;
      end else begin
         if (csr_valid && csr_ready)
            edge_cfg <= csr_data;
         if (req_tvalid && req_tready)
            distance_due.push_back(box_distance(req_tdata[CW-1:0], req_tdata[2*CW-1:CW],
                                                req_tdata[3*CW-1:2*CW], edge_cfg));
         if (rsp_tvalid && rsp_tready) begin
            if (distance_due.size() == 0) begin
               note_fault($sformatf("unexpected result distance=%0d",
                                    $signed(rsp_tdata[OUT_W-1:0])));
            end else begin
               want = distance_due.pop_front();
               if (rsp_tdata[OUT_W-1:0] !== want)
                  note_fault($sformatf("distance mismatch: expected %0d, got %0d",
                                       want, $signed(rsp_tdata[OUT_W-1:0])));
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_box_signed_distance_unit: done, errors");
            $finish;
         end
      end
   end

   task automatic add_point(int x, int y, int z);
      point_t p;
      p.x = coord_t'(x);
      p.y = coord_t'(y);
      p.z = coord_t'(z);
      pending.push_back(p);
   endtask

   // sender stays quiet until every outstanding request has been answered
   task automatic drain();
      do begin
         @(posedge clock);
         #1;
      end while (pending.size() != 0 || req_tvalid || distance_due.size() != 0);
   endtask

   task automatic write_edge(logic [EDGE_W-1:0] value);
      @(negedge clock);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do
         @(negedge clock);
      while (!csr_taken);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic add_random(int count, logic [EDGE_W-1:0] edge_len);
      int half;
      half = int'(edge_len >> 1);
      repeat (count)
         add_point(pick_coord(half), pick_coord(half), pick_coord(half));
   endtask

   initial begin
      logic [EDGE_W-1:0] edges[6];
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // default edge: on the face, just inside, just outside, extremes
      add_point(0, 0, 0);
      add_point(128, 0, 0);
      add_point(0, 0, -128);
      add_point(127, -127, 50);
      add_point(129, 0, 0);
      add_point(0, -129, 0);
      add_point(32767, 32767, 32767);
      add_point(-32768, -32768, -32768);
      add_point(-32768, 32767, 0);
      drain();

      // zero edge: plain Euclidean length
      write_edge(16'h0000);
      add_point(0, 0, 0);
      add_point(768, -1024, 0);
      add_point(-32768, -32768, -32768);
      add_point(32767, -1, 1);
      drain();

      // largest edge: nearly every point inside
      write_edge(16'hFFFF);
      add_point(0, 0, 0);
      add_point(32767, 0, 0);
      add_point(-32768, 0, 0);
      add_point(-32768, -32768, -32768);
      drain();

      // odd edge: low bit dropped when halving
      write_edge(16'd257);
      add_point(128, 0, 0);
      add_point(-129, 5, 5);
      drain();

      edges[0] = 16'h0001;
      edges[1] = 16'hFFFE;
      edges[2] = 16'($urandom);
      edges[3] = 16'h0000;
      edges[4] = 16'($urandom_range(0, 4096));
      edges[5] = 16'hFFFF;
      foreach (edges[i]) begin
         write_edge(edges[i]);
         add_random(50, edges[i]);
         drain();
         add_random(50, edges[i]);
         drain();
      end

      repeat (40) @(posedge clock);
      #1;
      if (distance_due.size() != 0)
         note_fault($sformatf("%0d results never arrived", distance_due.size()));
      if (fault_count == 0)
         $display("tb_box_signed_distance_unit: done, clean");
      else
         $display("tb_box_signed_distance_unit: done, errors");
      $finish;
   end

endmodule
